[hw/rtl/bilinear_pixel_sampler_core_defines.svh]
// ----------------------------------------------------------------------------
// bilinear pixel sampler core - assertion macros
// Shared concurrent assertion forms for the sampler core.
// ----------------------------------------------------------------------------
`ifndef BILINEAR_PIXEL_SAMPLER_CORE_DEFINES_SVH
`define BILINEAR_PIXEL_SAMPLER_CORE_DEFINES_SVH

// same-cycle implication
`define BPS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/bps_pkg.sv]
// ----------------------------------------------------------------------------
// bps_pkg
// Types, constants and helpers shared by the bilinear pixel sampler modules.
// ----------------------------------------------------------------------------
package bps_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int DEF_FRAC_BITS  = 8;

  localparam int COORD_W    = 16;
  localparam int PIX_W      = 16;
  localparam int ADDR_IN_W  = 16;
  localparam int REG_W      = 9;
  localparam int REG_IDX_W  = 1;
  localparam int OUT_W      = 32;
  localparam int SRC_ADDR_W = 2 * REG_W;
  localparam int WRAP_W     = 48;
  localparam int WGT_MAX_W  = 25;

  localparam logic [REG_W-1:0] ROW_WIDTH_RESET = 9'd256;
  localparam logic [REG_W-1:0] ROW_COUNT_RESET = 9'd256;

  localparam int QUEUE_DEPTH = 2;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic [REG_IDX_W-1:0] REG_ROW_WIDTH = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_ROW_COUNT = 1'b1;

  typedef enum logic [1:0] {
    KIND_WRITE,
    KIND_SAMPLE,
    KIND_CLIP
  } kind_t;

  typedef struct packed {
    logic [REG_W-1:0] row_width;
    logic [REG_W-1:0] row_count;
  } cfg_t;

  typedef struct packed {
    kind_t                          kind;
    logic [SRC_ADDR_W-1:0]          base;
    logic [REG_W-1:0]               x0;
    logic [PIX_W-1:0]               value;
    logic [3:0][WGT_MAX_W-1:0]      wgt;
  } entry_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_stat_t;

  // reduce an address modulo the store depth by shifted compare and subtract
  function automatic logic [SRC_ADDR_W-1:0] wrap_addr(input logic [SRC_ADDR_W-1:0] a,
                                                      input logic [WRAP_W-1:0] depth);
    logic [WRAP_W-1:0] r;
    r = WRAP_W'(a);
    for (int k = SRC_ADDR_W - 1; k >= 0; k--) begin
      if (r >= (depth << k)) begin
        r = r - (depth << k);
      end
    end
    return r[SRC_ADDR_W-1:0];
  endfunction

endpackage

[hw/rtl/bps_front.sv]
// ----------------------------------------------------------------------------
// bps_front
// Holds the configuration registers and classifies each request: write,
// in-range sample or clipped sample. Works out the row base and the weights.
// ----------------------------------------------------------------------------
module bps_front #(
  parameter int FRAC_BITS = bps_pkg::DEF_FRAC_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [bps_pkg::REG_IDX_W-1:0]   cfg_index,
  input  logic [bps_pkg::REG_W-1:0]       cfg_data,
  input  logic                            op,
  input  logic [bps_pkg::ADDR_IN_W-1:0]   pixel_address,
  input  logic signed [bps_pkg::PIX_W-1:0] pixel_value,
  input  logic [bps_pkg::COORD_W-1:0]     x_coord,
  input  logic [bps_pkg::COORD_W-1:0]     y_coord,
  output bps_pkg::cfg_t                   cfg,
  output bps_pkg::entry_t                 entry
);

  localparam int INT_W = bps_pkg::COORD_W - FRAC_BITS;
  localparam int CMP_W = bps_pkg::COORD_W + 1;
  localparam int WGT_W = 2 * FRAC_BITS + 1;
  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic [INT_W-1:0]                  x_int;
  logic [INT_W-1:0]                  y_int;
  logic [CMP_W-1:0]                  x_next;
  logic [CMP_W-1:0]                  y_next;
  logic                              clip;
  logic [bps_pkg::SRC_ADDR_W-1:0]    row0;
  logic [FRAC_BITS:0]                wx0, wx1, wy0, wy1;
  logic [WGT_W-1:0]                  w00, w10, w01, w11;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.row_width <= bps_pkg::ROW_WIDTH_RESET;
      cfg.row_count <= bps_pkg::ROW_COUNT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        bps_pkg::REG_ROW_WIDTH: cfg.row_width <= cfg_data;
        bps_pkg::REG_ROW_COUNT: cfg.row_count <= cfg_data;
        default: ;
      endcase
    end
  end

  assign x_int  = x_coord[bps_pkg::COORD_W-1:FRAC_BITS];
  assign y_int  = y_coord[bps_pkg::COORD_W-1:FRAC_BITS];
  assign x_next = CMP_W'(x_int) + CMP_W'(1);
  assign y_next = CMP_W'(y_int) + CMP_W'(1);
  assign clip   = (x_next >= CMP_W'(cfg.row_width)) || (y_next >= CMP_W'(cfg.row_count));

  assign row0 = bps_pkg::SRC_ADDR_W'(bps_pkg::REG_W'(y_int))
              * bps_pkg::SRC_ADDR_W'(cfg.row_width);

  assign wx1 = (FRAC_BITS + 1)'(x_coord[FRAC_BITS-1:0]);
  assign wy1 = (FRAC_BITS + 1)'(y_coord[FRAC_BITS-1:0]);
  assign wx0 = ONE - wx1;
  assign wy0 = ONE - wy1;

  assign w00 = WGT_W'(wx0) * WGT_W'(wy0);
  assign w10 = WGT_W'(wx1) * WGT_W'(wy0);
  assign w01 = WGT_W'(wx0) * WGT_W'(wy1);
  assign w11 = WGT_W'(wx1) * WGT_W'(wy1);

  always_comb begin
    entry.x0     = bps_pkg::REG_W'(x_int);
    entry.value  = pixel_value;
    entry.wgt[0] = bps_pkg::WGT_MAX_W'(w00);
    entry.wgt[1] = bps_pkg::WGT_MAX_W'(w10);
    entry.wgt[2] = bps_pkg::WGT_MAX_W'(w01);
    entry.wgt[3] = bps_pkg::WGT_MAX_W'(w11);
    unique case (op)
      bps_pkg::OP_WRITE: begin
        entry.kind = bps_pkg::KIND_WRITE;
        entry.base = bps_pkg::SRC_ADDR_W'(pixel_address);
      end
      bps_pkg::OP_SAMPLE: begin
        entry.kind = clip ? bps_pkg::KIND_CLIP : bps_pkg::KIND_SAMPLE;
        entry.base = row0;
      end
      default: begin
        entry.kind = bps_pkg::KIND_WRITE;
        entry.base = bps_pkg::SRC_ADDR_W'(pixel_address);
      end
    endcase
  end

endmodule

[hw/rtl/bps_queue.sv]
// ----------------------------------------------------------------------------
// bps_queue
// Short request queue between the front and the back of the sampler.
// ----------------------------------------------------------------------------
module bps_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  bps_pkg::entry_t   push_entry,
  input  logic              pop,
  output bps_pkg::entry_t   head,
  output bps_pkg::q_stat_t  stat
);

  localparam int PTR_W = $clog2(bps_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(bps_pkg::QUEUE_DEPTH + 1);

  bps_pkg::entry_t  slots [bps_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        slots[wr_ptr] <= push_entry;
        wr_ptr        <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  assign head       = slots[rd_ptr];
  assign stat.valid = (count != '0);
  assign stat.full  = (count == CNT_W'(bps_pkg::QUEUE_DEPTH));

endmodule

[hw/rtl/bps_back.sv]
// ----------------------------------------------------------------------------
// bps_back
// Executes queued requests: pixel writes into the image store, and samples
// as four sequential neighbour reads, a weight multiply and an accumulate.
// ----------------------------------------------------------------------------
module bps_back #(
  parameter int MAX_WIDTH  = bps_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bps_pkg::DEF_MAX_HEIGHT,
  parameter int FRAC_BITS  = bps_pkg::DEF_FRAC_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  bps_pkg::cfg_t                      cfg,
  input  bps_pkg::q_stat_t                   q_stat,
  input  bps_pkg::entry_t                    q_head,
  output logic                               q_pop,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [bps_pkg::OUT_W-1:0]   sample_value,
  output logic                               out_of_range
);

  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int WGT_W       = 2 * FRAC_BITS + 1;
  localparam int PROD_W      = WGT_W + bps_pkg::PIX_W + 1;
  localparam int LSH         = (2 * FRAC_BITS <= 16) ? 16 - 2 * FRAC_BITS : 0;
  localparam int RSH         = (2 * FRAC_BITS > 16) ? 2 * FRAC_BITS - 16 : 0;
  localparam int WIDE_W      = PROD_W + LSH;
  localparam logic [1:0] LAST_PHASE = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_WAIT
  } state_t;

  logic [bps_pkg::PIX_W-1:0]        mem [STORE_DEPTH];

  state_t                           state;
  logic [1:0]                       phase;
  logic [bps_pkg::SRC_ADDR_W-1:0]   base;
  logic [bps_pkg::REG_W-1:0]        x0;
  logic [3:0][WGT_W-1:0]            wgt;
  logic                             rd_vld;
  logic [1:0]                       rd_ph;
  logic [bps_pkg::PIX_W-1:0]        rd_data;
  logic                             mul_vld;
  logic                             mul_last;
  logic signed [PROD_W-1:0]         prod;
  logic signed [PROD_W-1:0]         acc;

  logic                             wr_en;
  logic [ADDR_W-1:0]                wr_idx;
  logic                             rd_en;
  logic [bps_pkg::SRC_ADDR_W-1:0]   offset;
  logic [bps_pkg::SRC_ADDR_W-1:0]   rd_src;
  logic [ADDR_W-1:0]                rd_idx;
  logic [WGT_W-1:0]                 wgt_sel;
  logic signed [PROD_W-1:0]         prod_next;
  logic signed [PROD_W-1:0]         total;
  logic signed [WIDE_W-1:0]         wide;
  logic signed [WIDE_W-1:0]         shifted;
  logic                             can_pop;
  logic                             res_load;

  // a sample or clip may start only when the result register is free
  assign can_pop = q_stat.valid && ((q_head.kind == bps_pkg::KIND_WRITE) ||
                                    !out_valid || out_ready);
  assign q_pop   = (state == S_IDLE) && can_pop;

  assign wr_en  = q_pop && (q_head.kind == bps_pkg::KIND_WRITE);
  assign wr_idx = ADDR_W'(bps_pkg::wrap_addr(q_head.base,
                                             bps_pkg::WRAP_W'(STORE_DEPTH)));

  assign rd_en = (state == S_RUN);

  // a new result enters the result register
  assign res_load = (q_pop && (q_head.kind == bps_pkg::KIND_CLIP)) ||
                    ((state == S_WAIT) && mul_vld && mul_last);

  always_comb begin
    case (phase)
      2'd0:    offset = '0;
      2'd1:    offset = bps_pkg::SRC_ADDR_W'(1);
      2'd2:    offset = bps_pkg::SRC_ADDR_W'(cfg.row_width);
      default: offset = bps_pkg::SRC_ADDR_W'(cfg.row_width) + bps_pkg::SRC_ADDR_W'(1);
    endcase
  end

  assign rd_src = base + bps_pkg::SRC_ADDR_W'(x0) + offset;
  assign rd_idx = ADDR_W'(bps_pkg::wrap_addr(rd_src, bps_pkg::WRAP_W'(STORE_DEPTH)));

  assign wgt_sel   = wgt[rd_ph];
  assign prod_next = $signed(rd_data) * $signed({1'b0, wgt_sel});

  assign total   = acc + prod;
  assign wide    = WIDE_W'(total);
  assign shifted = (wide <<< LSH) >>> RSH;

  // image store: one write or one read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= q_head.value;
    end
    if (rd_en) begin
      rd_data <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= '0;
      rd_vld    <= 1'b0;
      mul_vld   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_vld   <= rd_en;
      rd_ph    <= phase;
      mul_vld  <= rd_vld;
      mul_last <= rd_vld && (rd_ph == LAST_PHASE);
      prod     <= prod_next;

      if (mul_vld && !mul_last) begin
        acc <= acc + prod;
      end

      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (q_pop) begin
            case (q_head.kind)
              bps_pkg::KIND_SAMPLE: begin
                base   <= q_head.base;
                x0     <= q_head.x0;
                wgt[0] <= WGT_W'(q_head.wgt[0]);
                wgt[1] <= WGT_W'(q_head.wgt[1]);
                wgt[2] <= WGT_W'(q_head.wgt[2]);
                wgt[3] <= WGT_W'(q_head.wgt[3]);
                phase  <= '0;
                acc    <= '0;
                state  <= S_RUN;
              end
              bps_pkg::KIND_CLIP: begin
                sample_value <= '0;
                out_of_range <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        S_RUN: begin
          phase <= phase + 2'd1;
          if (phase == LAST_PHASE) begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (mul_vld && mul_last) begin
            sample_value <= shifted[bps_pkg::OUT_W-1:0];
            out_of_range <= 1'b0;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[hw/rtl/bilinear_pixel_sampler_core.sv]
// ----------------------------------------------------------------------------
// bilinear_pixel_sampler_core
// Image store with pixel writes and bilinear sampling at fixed-point positions.
// ----------------------------------------------------------------------------
// Requests enter on in_valid/in_ready: op selects a pixel write (pixel_address,
// pixel_value) or a sample (x_coord, y_coord). Only samples give a result on
// out_valid/out_ready: sample_value with 16 fraction bits and out_of_range,
// which is set with a zero value when a +1 neighbour falls outside row_width
// or row_count. Those registers are written on cfg_write/cfg_index/cfg_data.
// A two-entry request queue sits between the front and the back, so the block
// keeps taking requests while a result waits for the receiver.
// A pixel write or clipped sample is executed as it is popped from the queue.
// An in-range sample makes four neighbour reads through the single store read
// port, then a multiply stage and an accumulate stage. When out_ready is low,
// one result is held and the back pauses before the next sample; writes ahead
// of it keep draining until a sample reaches the queue head.
// Reset clears the queue, the result register and the configuration to
// 256 x 256; the image store keeps its contents and needs no clearing.
// ----------------------------------------------------------------------------
`include "bilinear_pixel_sampler_core_defines.svh"

module bilinear_pixel_sampler_core #(
  parameter int MAX_WIDTH  = bps_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bps_pkg::DEF_MAX_HEIGHT,
  parameter int FRAC_BITS  = bps_pkg::DEF_FRAC_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [bps_pkg::REG_IDX_W-1:0]      cfg_index,
  input  logic [bps_pkg::REG_W-1:0]          cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               op,
  input  logic [bps_pkg::ADDR_IN_W-1:0]      pixel_address,
  input  logic signed [bps_pkg::PIX_W-1:0]   pixel_value,
  input  logic [bps_pkg::COORD_W-1:0]        x_coord,
  input  logic [bps_pkg::COORD_W-1:0]        y_coord,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [bps_pkg::OUT_W-1:0]   sample_value,
  output logic                               out_of_range
);

  bps_pkg::cfg_t     cfg;
  bps_pkg::entry_t   front_entry;
  bps_pkg::entry_t   q_head;
  bps_pkg::q_stat_t  q_stat;
  logic              q_push;
  logic              q_pop;

  assign in_ready = !q_stat.full;
  assign q_push   = in_valid && in_ready;

  bps_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .op            (op),
    .pixel_address (pixel_address),
    .pixel_value   (pixel_value),
    .x_coord       (x_coord),
    .y_coord       (y_coord),
    .cfg           (cfg),
    .entry         (front_entry)
  );

  bps_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (front_entry),
    .pop        (q_pop),
    .head       (q_head),
    .stat       (q_stat)
  );

  bps_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_stat       (q_stat),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sample_value (sample_value),
    .out_of_range (out_of_range)
  );

  `BPS_ASSERT_NOW(a_clip_zero, clk, rst, out_valid && out_of_range, sample_value == '0, "clipped sample with nonzero value")
  `BPS_ASSERT_NOW(a_pop_nonempty, clk, rst, q_pop, q_stat.valid, "pop from empty request queue")
  `BPS_ASSERT_NOW(a_full_after_push, clk, rst, $fell(in_ready), $past(in_valid), "queue filled without a request")

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for bilinear_pixel_sampler_core. Directed pixel writes
// and samples at the edges of the default 256 x 256 image come first. Random
// phases follow under several row_width/row_count settings, among them 0, 1, 2
// and 511. Every four-pixel neighbourhood is written before it is sampled.
// Each accepted sample request is predicted here and compared with the block's
// output in order. Both handshake sides idle at random.
// ----------------------------------------------------------------------------
module tb;

  localparam int FRAC           = bps_pkg::DEF_FRAC_BITS;
  localparam int DEPTH          = bps_pkg::DEF_MAX_WIDTH * bps_pkg::DEF_MAX_HEIGHT;
  localparam int NUM_DIRECTED   = 24;
  localparam int NUM_PHASES     = 8;
  localparam int PHASE_REQUESTS = 75;
  localparam int SETTLE         = 16;

  typedef struct packed {
    logic signed [31:0] value;
    logic               clipped;
  } sample_t;

  typedef struct packed {
    logic        op;
    logic [15:0] addr;
    logic [15:0] pix;
    logic [15:0] x;
    logic [15:0] y;
    logic        pinned;
    logic [31:0] value;
    logic        clipped;
  } request_t;

  localparam request_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    '{bps_pkg::OP_WRITE,  16'h0000, 16'h7fff, 16'hffff, 16'hffff, 1'b0, 32'h0, 1'b0},
    '{bps_pkg::OP_WRITE,  16'h0001, 16'h8000, 16'h0000, 16'h0000, 1'b0, 32'h0, 1'b0},
    '{bps_pkg::OP_WRITE,  16'h0100, 16'h1234, 16'hffff, 16'h0000, 1'b0, 32'h0, 1'b0},
    '{bps_pkg::OP_WRITE,  16'h0101, 16'hffff, 16'h0000, 16'hffff, 1'b0, 32'h0, 1'b0},
    '{bps_pkg::OP_SAMPLE, 16'hffff, 16'h7fff, 16'h0000, 16'h0000, 1'b1, 32'h7fff0000, 1'b0},
    '{bps_pkg::OP_SAMPLE, 16'hffff, 16'h8000, 16'h0080, 16'h0000, 1'b0, 32'h0, 1'b0},
    '{bps_pkg::OP_SAMPLE, 16'h0000, 16'hffff, 16'h00ff, 16'h00ff, 1'b0, 32'h0, 1'b0},
    '{bps_pkg::OP_SAMPLE, 16'hffff, 16'h0000, 16'h0080, 16'h0080, 1'b0, 32'h0, 1'b0},
    '{bps_pkg::OP_SAMPLE, 16'h5555, 16'haaaa, 16'h0001, 16'h00fe, 1'b0, 32'h0, 1'b0},
    '{bps_pkg::OP_SAMPLE, 16'hffff, 16'h7fff, 16'hff00, 16'h0000, 1'b1, 32'h0, 1'b1},
    '{bps_pkg::OP_SAMPLE, 16'h0000, 16'h8000, 16'h0000, 16'hff00, 1'b1, 32'h0, 1'b1},
    '{bps_pkg::OP_SAMPLE, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 1'b1, 32'h0, 1'b1},
    '{bps_pkg::OP_WRITE,  16'h0200, 16'h8000, 16'h0000, 16'h0000, 1'b0, 32'h0, 1'b0},
    '{bps_pkg::OP_WRITE,  16'h0201, 16'h8000, 16'h0000, 16'h0000, 1'b0, 32'h0, 1'b0},
    '{bps_pkg::OP_WRITE,  16'h0300, 16'h8000, 16'h0000, 16'h0000, 1'b0, 32'h0, 1'b0},
    '{bps_pkg::OP_WRITE,  16'h0301, 16'h8000, 16'h0000, 16'h0000, 1'b0, 32'h0, 1'b0},
    '{bps_pkg::OP_SAMPLE, 16'hffff, 16'h7fff, 16'h0080, 16'h0280, 1'b1, 32'h80000000, 1'b0},
    '{bps_pkg::OP_WRITE,  16'hfefe, 16'h0001, 16'hffff, 16'hffff, 1'b0, 32'h0, 1'b0},
    '{bps_pkg::OP_WRITE,  16'hfeff, 16'h7fff, 16'hffff, 16'hffff, 1'b0, 32'h0, 1'b0},
    '{bps_pkg::OP_WRITE,  16'hfffe, 16'h8000, 16'hffff, 16'hffff, 1'b0, 32'h0, 1'b0},
    '{bps_pkg::OP_WRITE,  16'hffff, 16'h5a5a, 16'hffff, 16'hffff, 1'b0, 32'h0, 1'b0},
    '{bps_pkg::OP_SAMPLE, 16'h0000, 16'h0000, 16'hfe00, 16'hfe00, 1'b1, 32'h00010000, 1'b0},
    '{bps_pkg::OP_SAMPLE, 16'hffff, 16'hffff, 16'hfeff, 16'hfeff, 1'b0, 32'h0, 1'b0},
    '{bps_pkg::OP_SAMPLE, 16'h1234, 16'h4321, 16'hfe01, 16'hfe80, 1'b0, 32'h0, 1'b0}
  };

  logic                                clk;
  logic                                rst           = 1'b1;
  logic                                cfg_write     = 1'b0;
  logic [bps_pkg::REG_IDX_W-1:0]       cfg_index     = bps_pkg::REG_ROW_WIDTH;
  logic [bps_pkg::REG_W-1:0]           cfg_data      = '0;
  logic                                in_valid      = 1'b0;
  logic                                in_ready;
  logic                                op            = bps_pkg::OP_WRITE;
  logic [bps_pkg::ADDR_IN_W-1:0]       pixel_address = '0;
  logic signed [bps_pkg::PIX_W-1:0]    pixel_value   = '0;
  logic [bps_pkg::COORD_W-1:0]         x_coord       = '0;
  logic [bps_pkg::COORD_W-1:0]         y_coord       = '0;
  logic                                out_valid;
  logic                                out_ready     = 1'b0;
  logic signed [bps_pkg::OUT_W-1:0]    sample_value;
  logic                                out_of_range;

  // typed expectation travelling with the request
  logic        cur_pinned  = 1'b0;
  logic [31:0] cur_value   = '0;
  logic        cur_clipped = 1'b0;

  logic [15:0] pixel_mem   [DEPTH];
  bit          pixel_known [DEPTH];
  logic [bps_pkg::REG_W-1:0] geom_width  = bps_pkg::ROW_WIDTH_RESET;
  logic [bps_pkg::REG_W-1:0] geom_height = bps_pkg::ROW_COUNT_RESET;

  sample_t expected_samples [$];
  int      mismatches    = 0;
  int      requests_sent = 0;
  int      gapless_left  = 0;

  bilinear_pixel_sampler_core dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .op            (op),
    .pixel_address (pixel_address),
    .pixel_value   (pixel_value),
    .x_coord       (x_coord),
    .y_coord       (y_coord),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .sample_value  (sample_value),
    .out_of_range  (out_of_range)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("bilinear_pixel_sampler_core: mismatch");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("%0t: %s", $time, what);
    mismatches++;
  endtask

  function automatic bit in_range(input logic [15:0] xc, input logic [15:0] yc);
    return (int'(xc >> FRAC) + 1 < int'(geom_width)) &&
           (int'(yc >> FRAC) + 1 < int'(geom_height));
  endfunction

  // bit 0 of corner steps one column right, bit 1 one row down
  function automatic int unsigned corner_addr(input logic [15:0] xc, input logic [15:0] yc,
                                              input int corner);
    longint unsigned a;
    a = longint'((yc >> FRAC) + corner[1]) * geom_width + (xc >> FRAC) + corner[0];
    return int'(a % DEPTH);
  endfunction

  function automatic longint pixel_at(input int unsigned a);
    return longint'($signed(pixel_mem[a]));
  endfunction

  function automatic sample_t interpolate(input logic [15:0] xc, input logic [15:0] yc);
    sample_t s;
    longint  one, fx, fy, acc;
    int      sh;
    s.value   = '0;
    s.clipped = 1'b1;
    if (!in_range(xc, yc)) return s;
    one = longint'(1) << FRAC;
    fx  = xc & (one - 1);
    fy  = yc & (one - 1);
    acc = (one - fx) * (one - fy) * pixel_at(corner_addr(xc, yc, 0))
        + fx * (one - fy) * pixel_at(corner_addr(xc, yc, 1))
        + (one - fx) * fy * pixel_at(corner_addr(xc, yc, 2))
        + fx * fy * pixel_at(corner_addr(xc, yc, 3));
    sh = 2 * FRAC - 16;
    if (sh >= 0) acc = acc >>> sh;
    else acc = acc <<< (-sh);
    s.value   = acc[31:0];
    s.clipped = 1'b0;
    return s;
  endfunction

  always @(posedge clk) begin : check_ports
    sample_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h oor %b", sample_value, out_of_range));
        end else begin
          want = expected_samples.pop_front();
          if (sample_value !== want.value)
            report_mismatch($sformatf("sample_value got %h want %h", sample_value, want.value));
          if (out_of_range !== want.clipped)
            report_mismatch($sformatf("out_of_range got %b want %b", out_of_range, want.clipped));
        end
      end
      if (in_valid && in_ready) begin
        if (op == bps_pkg::OP_WRITE) begin
          pixel_mem[pixel_address % DEPTH] = pixel_value;
        end else if (cur_pinned) begin
          expected_samples.push_back('{cur_value, cur_clipped});
        end else begin
          expected_samples.push_back(interpolate(x_coord, y_coord));
        end
      end
    end
  end

  // receiver: ready runs with stalls, mostly short and a few long
  initial begin : receiver
    int r;
    int run;
    forever begin
      r   = $urandom_range(0, 99);
      run = (r < 15) ? $urandom_range(40, 150) : $urandom_range(1, 8);
      out_ready <= 1'b1;
      repeat (run) @(posedge clk);
      r = $urandom_range(0, 99);
      if (r < 75) run = $urandom_range(1, 3);
      else if (r < 95) run = $urandom_range(4, 12);
      else run = $urandom_range(20, 40);
      out_ready <= 1'b0;
      repeat (run) @(posedge clk);
    end
  end

  function automatic int pick_gap();
    int r;
    if (gapless_left > 0) begin
      gapless_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  task automatic send_request(input request_t req);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    op            <= req.op;
    pixel_address <= req.addr;
    pixel_value   <= req.pix;
    x_coord       <= req.x;
    y_coord       <= req.y;
    cur_pinned    <= req.pinned;
    cur_value     <= req.value;
    cur_clipped   <= req.clipped;
    if (req.op == bps_pkg::OP_WRITE) pixel_known[req.addr % DEPTH] = 1'b1;
    requests_sent++;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_write(input logic [15:0] addr, input logic [15:0] pix);
    send_request('{bps_pkg::OP_WRITE, addr, pix, 16'($urandom), 16'($urandom),
                   1'b0, 32'h0, 1'b0});
  endtask

  // write any unwritten neighbours first, sometimes overwrite one
  task automatic sample_at(input logic [15:0] xc, input logic [15:0] yc);
    int unsigned a;
    if (in_range(xc, yc)) begin
      for (int k = 0; k < 4; k++) begin
        a = corner_addr(xc, yc, k);
        if (!pixel_known[a]) send_write(16'(a), 16'($urandom));
      end
      if ($urandom_range(0, 4) == 0)
        send_write(16'(corner_addr(xc, yc, $urandom_range(0, 3))), 16'($urandom));
    end
    send_request('{bps_pkg::OP_SAMPLE, 16'($urandom), 16'($urandom), xc, yc,
                   1'b0, 32'h0, 1'b0});
  endtask

  function automatic logic [15:0] pick_coord(input int whole_max);
    int r;
    int f;
    r = $urandom_range(0, 9);
    if (r == 0) f = 0;
    else if (r == 1) f = (1 << FRAC) - 1;
    else f = $urandom_range(0, (1 << FRAC) - 1);
    return 16'(($urandom_range(0, whole_max) << FRAC) | f);
  endfunction

  task automatic random_step();
    int r;
    int xmax;
    int ymax;
    r = $urandom_range(0, 99);
    if (r < 70 && geom_width >= 2 && geom_height >= 2) begin
      xmax = (int'(geom_width) - 2 < 255) ? int'(geom_width) - 2 : 255;
      ymax = (int'(geom_height) - 2 < 255) ? int'(geom_height) - 2 : 255;
      sample_at(pick_coord(xmax), pick_coord(ymax));
    end else if (r < 85) begin
      send_write(16'($urandom), 16'($urandom));
    end else begin
      sample_at(16'($urandom), 16'($urandom));
    end
  endtask

  // stop requesting, wait for every result and let the back settle
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_samples.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_geometry(input int w, input int h);
    cfg_write <= 1'b1;
    cfg_index <= bps_pkg::REG_ROW_WIDTH;
    cfg_data  <= bps_pkg::REG_W'(w);
    @(posedge clk);
    cfg_index <= bps_pkg::REG_ROW_COUNT;
    cfg_data  <= bps_pkg::REG_W'(h);
    @(posedge clk);
    cfg_write   <= 1'b0;
    geom_width  = bps_pkg::REG_W'(w);
    geom_height = bps_pkg::REG_W'(h);
  endtask

  initial begin : stimulus
    int  w;
    int  h;
    int  phase_start;
    bit  paused;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_DIRECTED; i++) send_request(DIRECTED_ROWS[i]);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      drain();
      case (phase)
        0: begin w = 2; h = 2; end
        1: begin w = 511; h = 511; end
        2: begin w = 0; h = 256; end
        3: begin w = 256; h = 1; end
        4: begin w = 3; h = 300; end
        5: begin w = 256; h = 256; end
        6: begin w = $urandom_range(2, 256); h = $urandom_range(2, 256); end
        default: begin w = $urandom_range(0, 511); h = $urandom_range(0, 511); end
      endcase
      set_geometry(w, h);
      gapless_left = (phase % 2 == 1) ? 40 : 0;
      phase_start  = requests_sent;
      paused       = 1'b0;
      while (requests_sent - phase_start < PHASE_REQUESTS) begin
        random_step();
        if (phase == 5 && !paused && requests_sent - phase_start >= PHASE_REQUESTS / 2) begin
          drain();
          paused = 1'b1;
        end
      end
    end
    drain();

    if (mismatches == 0) begin
      $display("bilinear_pixel_sampler_core: match");
    end else begin
      $display("bilinear_pixel_sampler_core: mismatch");
    end
    $finish;
  end

endmodule
